// ===== hw/rtl/atrm_pkg.sv =====
// ----------------------------------------------------------------------------
// atrm_pkg: shared types and constants of the modem response matcher
// Word layouts, opcode and verdict codes, command word of the internal queue
// and the fixed response strings that the back end looks for.
// ----------------------------------------------------------------------------
package atrm_pkg;

    // History of received bytes, newest in the lowest byte
    localparam int HIST_DEPTH = 28;
    localparam int HIST_W     = 8 * HIST_DEPTH;

    // Terminator characters held in the two 64-bit registers
    localparam int TERM_BYTES = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int TERM_LEN_W  = 5;
    localparam int LIMIT_W     = 13;
    localparam int COUNT_W     = 13;
    localparam int TICKS_W     = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_TERM_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TERM_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TERM_LEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 2'd3;

    localparam logic [TERM_LEN_W-1:0] TERM_LEN_RESET = 5'd4;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 13'd4096;

    // Input opcodes
    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result verdicts
    typedef enum logic [2:0] {
        V_TERM       = 3'd0,
        V_CONNECTED  = 3'd1,
        V_ERROR      = 3'd2,
        V_BUSY       = 3'd3,
        V_BUF_FULL   = 3'd4,
        V_TIMEOUT    = 3'd5,
        V_BAD_SETUP  = 3'd6
    } t_verdict;

    // Channel words
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [15:0] timeout_ticks;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         verdict;
        logic [COUNT_W-1:0] bytes_seen;
    } t_out_word;

    // Command word between front and back end
    typedef enum logic [1:0] {
        K_ARM  = 2'd0,
        K_BYTE = 2'd1,
        K_TICK = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        bad_setup;
        logic [7:0]  data_byte;
        logic [15:0] budget;
    } t_cmd;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Fixed response strings, last character in the lowest byte
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam int PAT_CONN_LEN = 28;
    localparam int PAT_ERR_LEN  = 7;
    localparam int PAT_BUSY_LEN = 11;

    localparam logic [8*PAT_CONN_LEN-1:0] PAT_CONN =
        {"ALREADY CONNECTED", CH_CR, CH_LF, CH_CR, CH_LF, "ERROR", CH_CR, CH_LF};
    localparam logic [8*PAT_ERR_LEN-1:0]  PAT_ERR    = {"ERROR", CH_CR, CH_LF};
    localparam logic [8*PAT_BUSY_LEN-1:0] PAT_BUSY_P = {"busy p...", CH_CR, CH_LF};
    localparam logic [8*PAT_BUSY_LEN-1:0] PAT_BUSY_S = {"busy s...", CH_CR, CH_LF};

endpackage

// ===== hw/rtl/atrm_front.sv =====
// ----------------------------------------------------------------------------
// atrm_front: input word decode
// Takes input words, drops unused opcodes, flags arm words whose setup is
// invalid and pushes the resulting commands into the queue.
// ----------------------------------------------------------------------------
module atrm_front #(
    parameter int LIM_W = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  atrm_pkg::t_in_word                    i_in_data,
    output logic                                  o_in_stall,
    input  logic [atrm_pkg::TERM_LEN_W-1:0]       i_eff_len,
    input  logic [LIM_W-1:0]                      i_eff_limit,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output atrm_pkg::t_cmd                        o_push_cmd
);
    import atrm_pkg::*;

    logic take;

    // Stall while the queue has no room
    assign o_in_stall = i_q_full;
    assign take       = i_in_valid && !i_q_full;

    // Classify the word and build the command
    always_comb begin
        o_push               = 1'b0;
        o_push_cmd.kind      = K_ARM;
        o_push_cmd.data_byte = i_in_data.data_byte;
        o_push_cmd.budget    = i_in_data.timeout_ticks;
        o_push_cmd.bad_setup = (i_eff_limit <= LIM_W'(i_eff_len));
        case (i_in_data.opcode)
            OP_ARM: begin
                o_push          = take;
                o_push_cmd.kind = K_ARM;
            end
            OP_BYTE: begin
                o_push          = take;
                o_push_cmd.kind = K_BYTE;
            end
            OP_TICK: begin
                o_push          = take;
                o_push_cmd.kind = K_TICK;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // A stalled front never pushes
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("front pushed into a full queue");
`endif

endmodule

// ===== hw/rtl/atrm_queue.sv =====
// ----------------------------------------------------------------------------
// atrm_queue: command queue
// Short first-in first-out queue that decouples decode from matching.
// ----------------------------------------------------------------------------
module atrm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  atrm_pkg::t_cmd  i_push_cmd,
    output logic            o_full,
    output logic            o_valid,
    output atrm_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import atrm_pkg::*;

    t_cmd              r_entry [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/atrm_back.sv =====
// ----------------------------------------------------------------------------
// atrm_back: session state and response matching
// Holds the byte history, byte count and tick budget of the session, compares
// the history against the terminator and the fixed responses and registers
// the verdict word.
// ----------------------------------------------------------------------------
module atrm_back #(
    parameter int MAX_TERMINATOR_LEN = 16,
    parameter int LIM_W              = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  atrm_pkg::t_cmd                        i_q_cmd,
    output logic                                  o_pop,
    input  logic [63:0]                           i_term_low,
    input  logic [63:0]                           i_term_high,
    input  logic [atrm_pkg::TERM_LEN_W-1:0]       i_eff_len,
    input  logic [LIM_W-1:0]                      i_eff_limit,
    output logic                                  o_out_valid,
    output atrm_pkg::t_out_word                   o_out_data,
    input  logic                                  i_out_stall
);
    import atrm_pkg::*;

    // Session state
    logic [HIST_W-1:0]  r_hist;
    logic [COUNT_W-1:0] r_count;
    logic [TICKS_W-1:0] r_ticks;
    logic               r_armed;
    logic               r_zero;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic [HIST_W-1:0]  n_hist;
    logic [COUNT_W-1:0] n_count;
    logic [TICKS_W-1:0] n_ticks;
    logic               n_armed;
    logic               n_zero;
    t_out_word          n_out_data;

    logic               proceed;
    logic               has_res;
    logic [TICKS_W-1:0] tick_dec;

    logic [2*CFG_DATA_W-1:0]       term_bits;
    logic [7:0]                    tchar [MAX_TERMINATOR_LEN];
    logic [MAX_TERMINATOR_LEN-1:0] lane_sel;
    logic                          term_hit;
    logic                          conn_hit;
    logic                          err_hit;
    logic                          busy_hit;

    assign proceed = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop   = proceed;

    // Byte shifted into the history
    assign n_hist  = {r_hist[HIST_W-9:0], i_q_cmd.data_byte};
    assign n_count = r_count + 1'b1;
    assign n_zero  = r_zero || (i_q_cmd.data_byte == 8'd0);

    // Terminator characters, zero beyond the register pair
    assign term_bits = {i_term_high, i_term_low};
    for (genvar gi = 0; gi < MAX_TERMINATOR_LEN; gi++) begin : g_tchar
        if (gi < TERM_BYTES) begin : g_reg
            assign tchar[gi] = term_bits[8*gi +: 8];
        end else begin : g_zero
            assign tchar[gi] = 8'd0;
        end
    end

    // One compare lane per terminator length
    for (genvar gl = 1; gl <= MAX_TERMINATOR_LEN; gl++) begin : g_lane
        logic [gl-1:0] eq;
        for (genvar gc = 0; gc < gl; gc++) begin : g_chr
            assign eq[gc] = (n_hist[8*(gl-1-gc) +: 8] == tchar[gc]);
        end
        assign lane_sel[gl-1] = (&eq) && (i_eff_len == TERM_LEN_W'(gl));
    end

    assign term_hit = (i_eff_len == '0) ||
                      (!n_zero && (n_count >= COUNT_W'(i_eff_len)) && (|lane_sel));

    // Fixed responses, blocked once a zero byte has arrived
    assign conn_hit = !n_zero && (n_count >= COUNT_W'(PAT_CONN_LEN)) &&
                      (n_hist[8*PAT_CONN_LEN-1:0] == PAT_CONN);
    assign err_hit  = !n_zero && (n_count >= COUNT_W'(PAT_ERR_LEN)) &&
                      (n_hist[8*PAT_ERR_LEN-1:0] == PAT_ERR);
    assign busy_hit = !n_zero && (n_count >= COUNT_W'(PAT_BUSY_LEN)) &&
                      ((n_hist[8*PAT_BUSY_LEN-1:0] == PAT_BUSY_P) ||
                       (n_hist[8*PAT_BUSY_LEN-1:0] == PAT_BUSY_S));

    assign tick_dec = (r_ticks != '0) ? (r_ticks - 1'b1) : r_ticks;

    // Work out the command against the session state
    always_comb begin
        has_res               = 1'b0;
        n_out_data.verdict    = V_TERM;
        n_out_data.bytes_seen = r_count;
        n_armed               = r_armed;
        case (i_q_cmd.kind)
            K_ARM: begin
                if (i_q_cmd.bad_setup) begin
                    has_res               = 1'b1;
                    n_out_data.verdict    = V_BAD_SETUP;
                    n_out_data.bytes_seen = '0;
                    n_armed               = 1'b0;
                end else begin
                    n_armed = 1'b1;
                end
            end
            K_BYTE: begin
                n_out_data.bytes_seen = n_count;
                if (r_armed) begin
                    has_res = 1'b1;
                    if (term_hit) begin
                        n_out_data.verdict = V_TERM;
                    end else if (conn_hit) begin
                        n_out_data.verdict = V_CONNECTED;
                    end else if (err_hit) begin
                        n_out_data.verdict = V_ERROR;
                    end else if (busy_hit) begin
                        n_out_data.verdict = V_BUSY;
                    end else if (LIM_W'(n_count) >= i_eff_limit) begin
                        n_out_data.verdict = V_BUF_FULL;
                    end else begin
                        has_res = 1'b0;
                    end
                    if (has_res) begin
                        n_armed = 1'b0;
                    end
                end
            end
            K_TICK: begin
                if (r_armed && (tick_dec == '0)) begin
                    has_res            = 1'b1;
                    n_out_data.verdict = V_TIMEOUT;
                    n_armed            = 1'b0;
                end
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    // Next tick budget
    always_comb begin
        n_ticks = r_ticks;
        case (i_q_cmd.kind)
            K_ARM: begin
                n_ticks = i_q_cmd.bad_setup ? '0 : ({1'b0, i_q_cmd.budget} + 1'b1);
            end
            K_TICK: begin
                if (r_armed) begin
                    n_ticks = tick_dec;
                end
            end
            default: begin
                n_ticks = r_ticks;
            end
        endcase
    end

    // Update the session
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_count <= '0;
            r_ticks <= '0;
            r_armed <= 1'b0;
            r_zero  <= 1'b0;
        end else if (proceed) begin
            r_armed <= n_armed;
            r_ticks <= n_ticks;
            if (i_q_cmd.kind == K_ARM) begin
                r_hist  <= '0;
                r_count <= '0;
                r_zero  <= 1'b0;
            end else if ((i_q_cmd.kind == K_BYTE) && r_armed) begin
                r_hist  <= n_hist;
                r_count <= n_count;
                r_zero  <= n_zero;
            end
        end
    end

    // Output register: load a new verdict, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && has_res) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // Every verdict ends the session
    a_verdict_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proceed && has_res) |=> !r_armed)
        else $error("session still armed after a verdict");

    // A failed setup reports no bytes
    a_bad_setup_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.verdict == V_BAD_SETUP)) |-> (r_out_data.bytes_seen == '0))
        else $error("bad setup verdict with bytes counted");

    // A pending timeout verdict leaves the tick budget spent
    a_timeout_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.verdict == V_TIMEOUT)) |-> (r_ticks == '0))
        else $error("timeout verdict with ticks left");
`endif

endmodule

// ===== hw/rtl/at_response_matcher.sv =====
// ----------------------------------------------------------------------------
// at_response_matcher: modem response matcher
// Arms a session with a tick budget, then watches received bytes and ticks
// for a terminator, a fixed modem response, a full buffer or a timeout.
//
//   channel   direction  handshake                 word
//   in        receive    i_in_valid / o_in_stall   t_in_word (opcode, byte, budget)
//   out       send       o_out_valid / i_out_stall t_out_word (verdict, bytes_seen)
//   cfg       receive    i_cfg_we                  index and 64-bit data
//
// One word a cycle is taken while o_in_stall is low; its verdict is registered
// in the back end. The rate is set by the back end, which handles one command a
// cycle while its output is free or being taken. A two-word queue sits between
// decode and matching; o_in_stall rises only when it is full, from registers alone.
// Synchronous reset clears session, queue and output; registers take reset values.
// ----------------------------------------------------------------------------
module at_response_matcher #(
    parameter int MAX_TERMINATOR_LEN = 16,
    parameter int BUFFER_CAPACITY    = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  atrm_pkg::t_in_word                    i_in_data,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output atrm_pkg::t_out_word                   o_out_data,
    input  logic                                  i_out_stall,
    input  logic                                  i_cfg_we,
    input  logic [atrm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [atrm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import atrm_pkg::*;

    localparam int CAP_W = $clog2(BUFFER_CAPACITY + 1);
    localparam int LIM_W = (CAP_W > LIMIT_W) ? CAP_W : LIMIT_W;

    logic [CFG_DATA_W-1:0] r_term_low;
    logic [CFG_DATA_W-1:0] r_term_high;
    logic [TERM_LEN_W-1:0] r_term_len;
    logic [LIMIT_W-1:0]    r_limit;

    logic [TERM_LEN_W-1:0] eff_len;
    logic [LIM_W-1:0]      eff_limit;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_low  <= '0;
            r_term_high <= '0;
            r_term_len  <= TERM_LEN_RESET;
            r_limit     <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TERM_LOW:  r_term_low  <= i_cfg_data;
                REG_TERM_HIGH: r_term_high <= i_cfg_data;
                REG_TERM_LEN:  r_term_len  <= i_cfg_data[TERM_LEN_W-1:0];
                REG_LIMIT:     r_limit     <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    r_term_len <= r_term_len;
                end
            endcase
        end
    end

    // Saturate terminator length and buffer limit
    assign eff_len   = (r_term_len > TERM_LEN_W'(MAX_TERMINATOR_LEN)) ?
                       TERM_LEN_W'(MAX_TERMINATOR_LEN) : r_term_len;
    assign eff_limit = (LIM_W'(r_limit) > LIM_W'(BUFFER_CAPACITY)) ?
                       LIM_W'(BUFFER_CAPACITY) : LIM_W'(r_limit);

    atrm_front #(
        .LIM_W (LIM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_eff_len  (eff_len),
        .i_eff_limit(eff_limit),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    atrm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (pop)
    );

    atrm_back #(
        .MAX_TERMINATOR_LEN (MAX_TERMINATOR_LEN),
        .LIM_W              (LIM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .i_term_low  (r_term_low),
        .i_term_high (r_term_high),
        .i_eff_len   (eff_len),
        .i_eff_limit (eff_limit),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== dv/at_response_matcher_test.sv =====
// ----------------------------------------------------------------------------
// at_response_matcher_test: self-checking bench for the modem response matcher
// Drives arm, byte and tick words through the valid/stall input channel and
// checks every verdict word against a local model of the session logic or the
// verdict a table row gives. A short table of hand-picked words comes first.
// Random modem traffic follows, under many terminator, limit and idling settings.
// ----------------------------------------------------------------------------
module at_response_matcher_test;
    import atrm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 10;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int NUM_PHASES    = 12;
    localparam int MAX_TERM      = 16;
    localparam int BUF_CAP       = 4096;

    // Opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // How a table row is checked
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_QUIET   = 2'd1;
    localparam logic [1:0] ROW_RESULT  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         data_byte;
        logic [15:0]        ticks;
        logic [1:0]         chk;
        logic [2:0]         verdict;
        logic [COUNT_W-1:0] bytes_seen;
    } t_row;

    // Hand-picked words, run with the reset settings (terminator never matches)
    localparam int NUM_ROWS = 25;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{OP_BYTE,   8'hff, 16'h0000, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_TICK,   8'h00, 16'h0000, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_UNUSED, 8'hff, 16'hffff, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_ARM,    8'h00, 16'h0000, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_TICK,   8'h00, 16'h0000, ROW_RESULT,  V_TIMEOUT,  13'd0},
        '{OP_ARM,    8'hff, 16'hffff, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_BYTE,   8'h00, 16'hffff, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_BYTE,   "E",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "O",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   CH_CR, 16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   CH_LF, 16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_ARM,    8'h00, 16'h0001, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_BYTE,   "E",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "O",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   "R",   16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   CH_CR, 16'h0000, ROW_PREDICT, V_TERM,     13'd0},
        '{OP_BYTE,   CH_LF, 16'h0000, ROW_RESULT,  V_ERROR,    13'd7},
        '{OP_ARM,    8'h00, 16'h0001, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_TICK,   8'h00, 16'h0000, ROW_QUIET,   V_TERM,     13'd0},
        '{OP_TICK,   8'h00, 16'h0000, ROW_RESULT,  V_TIMEOUT,  13'd0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    t_in_word               i_in_data;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_word              o_out_data;
    logic                   i_out_stall;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Local copy of the session state and settings
    logic [7:0]         hist [HIST_DEPTH];
    logic [COUNT_W-1:0] count;
    logic [TICKS_W-1:0] ticks;
    bit                 armed;
    bit                 zero_seen;
    logic [63:0]        term_lo;
    logic [63:0]        term_hi;
    logic [4:0]         term_len;
    logic [LIMIT_W-1:0] limit_reg;

    t_out_word verdicts_due [$];
    t_in_word  traffic [$];
    t_out_word due_word;
    int        errors;
    int        sent_words;
    int        tx_idle_pct;
    int        rx_stall_pct;

    at_response_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop for a hung run
    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Session model
    // ------------------------------------------------------------------
    function automatic int unsigned term_len_eff();
        return (term_len > MAX_TERM) ? MAX_TERM : term_len;
    endfunction

    function automatic int unsigned limit_eff();
        return (limit_reg > BUF_CAP) ? BUF_CAP : limit_reg;
    endfunction

    function automatic logic [7:0] term_char(input int unsigned i);
        return (i < 8) ? term_lo[8*i +: 8] : term_hi[8*(i-8) +: 8];
    endfunction

    // Does the fixed string (last character lowest) end at the newest byte
    function automatic bit tail_is(input logic [HIST_W-1:0] pat, input int unsigned len);
        if (count < len) return 1'b0;
        for (int k = 0; k < len; k++)
            if (hist[k] != pat[8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit term_hit(input int unsigned tlen);
        if (tlen == 0) return 1'b1;
        if (zero_seen || count < tlen) return 1'b0;
        for (int i = 0; i < tlen; i++)
            if (hist[tlen-1-i] != term_char(i)) return 1'b0;
        return 1'b1;
    endfunction

    // End the session with a verdict
    function automatic t_out_word close_session(input t_verdict v);
        t_out_word r;
        r.verdict    = v;
        r.bytes_seen = count;
        armed        = 1'b0;
        return r;
    endfunction

    // Apply one input word; returns 1 with the verdict when one is due
    function automatic bit judge_word(input t_in_word w, output t_out_word res);
        int unsigned tlen;
        tlen = term_len_eff();
        res  = '0;
        if (w.opcode == OP_ARM) begin
            for (int k = 0; k < HIST_DEPTH; k++) hist[k] = 8'h00;
            count     = '0;
            zero_seen = 1'b0;
            ticks     = {1'b0, w.timeout_ticks} + 1'b1;
            if (limit_eff() < tlen + 1) begin
                ticks = '0;
                res   = close_session(V_BAD_SETUP);
                return 1'b1;
            end
            armed = 1'b1;
            return 1'b0;
        end
        if (!armed) return 1'b0;
        if (w.opcode == OP_BYTE) begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
            hist[0] = w.data_byte;
            count   = count + 1'b1;
            if (w.data_byte == 8'h00) zero_seen = 1'b1;
            if (term_hit(tlen)) begin
                res = close_session(V_TERM);
                return 1'b1;
            end
            if (!zero_seen) begin
                if (tail_is(PAT_CONN, PAT_CONN_LEN)) begin
                    res = close_session(V_CONNECTED);
                    return 1'b1;
                end
                if (tail_is(PAT_ERR, PAT_ERR_LEN)) begin
                    res = close_session(V_ERROR);
                    return 1'b1;
                end
                if (tail_is(PAT_BUSY_P, PAT_BUSY_LEN) || tail_is(PAT_BUSY_S, PAT_BUSY_LEN)) begin
                    res = close_session(V_BUSY);
                    return 1'b1;
                end
            end
            if (count >= limit_eff()) begin
                res = close_session(V_BUF_FULL);
                return 1'b1;
            end
            return 1'b0;
        end
        if (w.opcode == OP_TICK) begin
            if (ticks != 0) ticks = ticks - 1'b1;
            if (ticks == 0) begin
                res = close_session(V_TIMEOUT);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_word make_word(input logic [1:0] op, input logic [7:0] b,
                                           input logic [15:0] t);
        t_in_word w;
        w.opcode        = op;
        w.data_byte     = b;
        w.timeout_ticks = t;
        return w;
    endfunction

    function automatic logic [15:0] random_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(5, 60));
        if (r < 85) return 16'($urandom_range(0, 4));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 8'($urandom_range(32, 126));
        if (r < 95) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue the first n characters of a fixed string
    task automatic push_prefix(input logic [HIST_W-1:0] pat, input int len, input int n);
        for (int i = 0; i < n; i++)
            traffic.push_back(make_word(OP_BYTE, pat[8*(len-1-i) +: 8], 16'($urandom)));
    endtask

    // Queue the first n terminator characters, or one odd byte when it is empty
    task automatic push_term(input int n);
        if (n == 0)
            traffic.push_back(make_word(OP_BYTE, noise_byte(), 16'($urandom)));
        for (int i = 0; i < n; i++)
            traffic.push_back(make_word(OP_BYTE, term_char(i), 16'($urandom)));
    endtask

    // Queue one session: an arm, then a few fragments of modem traffic
    task automatic queue_session();
        int frags;
        int r;
        int tlen;
        tlen  = term_len_eff();
        frags = $urandom_range(1, 5);
        traffic.push_back(make_word(OP_ARM, 8'($urandom), random_budget()));
        for (int f = 0; f < frags; f++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 3))
                    traffic.push_back(make_word(OP_TICK, 8'($urandom), 16'($urandom)));
            end else if (r < 10) begin
                traffic.push_back(make_word(OP_UNUSED, 8'($urandom), 16'($urandom)));
            end else if (r < 12) begin
                traffic.push_back(make_word(OP_ARM, 8'($urandom), random_budget()));
            end else if (r < 30) begin
                push_term(tlen);
            end else if (r < 40) begin
                push_prefix(PAT_ERR, PAT_ERR_LEN, PAT_ERR_LEN);
            end else if (r < 48) begin
                if ($urandom_range(0, 1) != 0)
                    push_prefix(PAT_BUSY_P, PAT_BUSY_LEN, PAT_BUSY_LEN);
                else
                    push_prefix(PAT_BUSY_S, PAT_BUSY_LEN, PAT_BUSY_LEN);
            end else if (r < 54) begin
                push_prefix(PAT_CONN, PAT_CONN_LEN, PAT_CONN_LEN);
            end else if (r < 62) begin
                // broken responses: a prefix that stops short
                case ($urandom_range(0, 3))
                    0: push_prefix(PAT_CONN, PAT_CONN_LEN, $urandom_range(1, PAT_CONN_LEN - 1));
                    1: push_prefix(PAT_ERR, PAT_ERR_LEN, $urandom_range(1, PAT_ERR_LEN - 1));
                    2: push_prefix(PAT_BUSY_S, PAT_BUSY_LEN, $urandom_range(1, PAT_BUSY_LEN - 1));
                    default: push_term((tlen > 1) ? $urandom_range(1, tlen - 1) : 0);
                endcase
            end else if (r < 66) begin
                traffic.push_back(make_word(OP_BYTE, 8'h00, 16'($urandom)));
            end else begin
                repeat ($urandom_range(1, 6))
                    traffic.push_back(make_word(OP_BYTE, noise_byte(), 16'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Offer one word, hold it until taken, then record what it should cause
    task automatic send_word(input t_in_word w, input logic [1:0] chk, input t_out_word typed);
        t_out_word guess;
        bit        has;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_words++;
        has = judge_word(w, guess);
        if (chk == ROW_RESULT)
            verdicts_due.push_back(typed);
        else if (chk == ROW_PREDICT && has)
            verdicts_due.push_back(guess);
        @(negedge i_clk);
    endtask

    // Write all four registers back to back
    task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic [LIMIT_W-1:0] lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TERM_LOW;
        i_cfg_data  <= lo;
        @(negedge i_clk);
        i_cfg_index <= REG_TERM_HIGH;
        i_cfg_data  <= hi;
        @(negedge i_clk);
        i_cfg_index <= REG_TERM_LEN;
        i_cfg_data  <= 64'(len);
        @(negedge i_clk);
        i_cfg_index <= REG_LIMIT;
        i_cfg_data  <= 64'(lim);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        term_lo   = lo;
        term_hi   = hi;
        term_len  = len;
        limit_reg = lim;
        @(negedge i_clk);
    endtask

    // Wait for every verdict, then let queued silent words drain
    task automatic drain();
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Check each verdict word against the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: expected no verdict, actual verdict %0d bytes %0d",
                         $time, o_out_data.verdict, o_out_data.bytes_seen);
            end else begin
                due_word = verdicts_due.pop_front();
                if (o_out_data.verdict !== due_word.verdict ||
                    o_out_data.bytes_seen !== due_word.bytes_seen) begin
                    errors++;
                    $display("%0t: expected verdict %0d bytes %0d, actual verdict %0d bytes %0d",
                             $time, due_word.verdict, due_word.bytes_seen,
                             o_out_data.verdict, o_out_data.bytes_seen);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [12:0] lim;
        int          mode;
        t_out_word   typed;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_TERM_LOW;
        i_cfg_data   = '0;
        errors       = 0;
        sent_words   = 0;
        tx_idle_pct  = 20;
        rx_stall_pct = 79;

        // Reset state of the model
        for (int k = 0; k < HIST_DEPTH; k++) hist[k] = 8'h00;
        count     = '0;
        ticks     = '0;
        armed     = 1'b0;
        zero_seen = 1'b0;
        term_lo   = '0;
        term_hi   = '0;
        term_len  = TERM_LEN_RESET;
        limit_reg = LIMIT_RESET;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the table of hand-picked words
        for (int r = 0; r < NUM_ROWS; r++) begin
            typed.verdict    = DIRECTED[r].verdict;
            typed.bytes_seen = DIRECTED[r].bytes_seen;
            send_word(make_word(DIRECTED[r].opcode, DIRECTED[r].data_byte, DIRECTED[r].ticks),
                      DIRECTED[r].chk, typed);
        end
        i_in_valid <= 1'b0;
        drain();

        // Random traffic under a series of settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            mode = p * 3 / NUM_PHASES;
            tx_idle_pct  = (mode == 0) ? 20 : (mode == 1) ? 79 : 0;
            rx_stall_pct = (mode == 0) ? 79 : (mode == 1) ? 20 : 0;
            target = 100;
            case (p)
                0: begin
                    // "OK\r\n"
                    lo = 64'h0000_0000_0a0d_4b4f; hi = '0; len = 5'd4; lim = 13'd4096;
                    target = 220;
                end
                1: begin
                    // full-length terminator of 0xff, limit above capacity
                    lo = '1; hi = '1; len = 5'd16; lim = 13'd8191;
                    target = 200;
                end
                2: begin
                    // empty terminator matches every byte
                    lo = 64'h0a0d; hi = '0; len = 5'd0; lim = 13'd1;
                    target = 120;
                end
                3: begin
                    // oversized length saturates; limit just clears it
                    lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
                    len = 5'd31; lim = 13'd17;
                    target = 150;
                end
                4: begin
                    // every arm is refused
                    lo = 64'h0a0d_4b4f; hi = '0; len = 5'd5; lim = 13'd0;
                    target = 60;
                end
                5: begin
                    // single line-feed terminator beats the fixed strings
                    lo = 64'h0a; hi = '0; len = 5'd1; lim = 13'd2;
                end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                    if ($urandom_range(0, 4) != 0) begin
                        for (int i = 0; i < 8; i++) begin
                            lo[8*i +: 8] = 8'($urandom_range(32, 126));
                            hi[8*i +: 8] = 8'($urandom_range(32, 126));
                        end
                    end
                    len = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 8))
                                                      : 5'($urandom_range(0, 31));
                    case ($urandom_range(0, 4))
                        0: lim = 13'($urandom_range(0, 8191));
                        1: lim = 13'd4096;
                        default: lim = 13'($urandom_range(10, 120));
                    endcase
                end
            endcase
            program_regs(lo, hi, len, lim);

            sent_words = 0;
            while (sent_words < target) begin
                if (traffic.size() == 0) queue_session();
                send_word(traffic.pop_front(), ROW_PREDICT, '0);
            end
            traffic.delete();
            i_in_valid <= 1'b0;
            drain();
        end

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
